>>> rtl/core/assert_macros.svh
// Assertion macros for the quaternion unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising edge, switched off while reset is high.
`define QAU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on the rising edge at all times, reset included.
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package qau_pkg;

  localparam int COMPONENT_WIDTH = 16;

  // component slots: x, y, z, w
  localparam int IX    = 0;
  localparam int IY    = 1;
  localparam int IZ    = 2;
  localparam int IW    = 3;
  localparam int LANES = 4;
  localparam int VEC   = 3;

  typedef enum logic [2:0] {
    OP_PRODUCT = 3'd0,
    OP_ROTATE  = 3'd1,
    OP_CONJ    = 3'd2,
    OP_DOT     = 3'd3,
    OP_SCALE   = 3'd4
  } op_t;

  // travels alongside the payload of every pipeline stage
  typedef struct packed {
    logic valid;
    op_t  op;
  } stage_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/qau_mul_stage.sv
// First pipeline stage: all sixteen A x B products (diagonal A x scale for OP_SCALE), registered.
// Depends on qau_pkg.
`default_nettype none

module qau_mul_stage #(
  parameter int W = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qau_pkg::stage_ctl_t  in_ctl,
  output logic                 in_ready,
  input  logic signed [W-1:0]  a [qau_pkg::LANES],
  input  logic signed [W-1:0]  b [qau_pkg::LANES],
  input  logic signed [W-1:0]  s,
  output qau_pkg::stage_ctl_t  out_ctl,
  input  logic                 out_ready,
  output logic signed [2*W-1:0] prod [qau_pkg::LANES][qau_pkg::LANES],
  output logic signed [W-1:0]  a_q [qau_pkg::LANES],
  output logic signed [W-1:0]  v_q [qau_pkg::VEC]
);

  localparam int PW = 2 * W;

  logic signed [W-1:0] b_op [qau_pkg::LANES][qau_pkg::LANES];

  assign in_ready = !out_ctl.valid || out_ready;

  // scale reuses the diagonal multipliers with the scalar as second operand
  always_comb begin
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      for (int j = 0; j < qau_pkg::LANES; j++) begin
        b_op[i][j] = (i == j && in_ctl.op == qau_pkg::OP_SCALE) ? s : b[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (in_ready) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int i = 0; i < qau_pkg::LANES; i++) begin
        for (int j = 0; j < qau_pkg::LANES; j++) begin
          prod[i][j] <= PW'(a[i]) * PW'(b_op[i][j]);
        end
        a_q[i] <= a[i];
      end
      for (int k = 0; k < qau_pkg::VEC; k++) begin
        v_q[k] <= b[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qau_sum_stage.sv
// Second pipeline stage: signed sums of the products per operation,
// cross product u x v for rotation, negation for conjugate. Depends on qau_pkg.
`default_nettype none

module qau_sum_stage #(
  parameter int W = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qau_pkg::stage_ctl_t    in_ctl,
  output logic                   in_ready,
  input  logic signed [2*W-1:0]  prod [qau_pkg::LANES][qau_pkg::LANES],
  input  logic signed [W-1:0]    a [qau_pkg::LANES],
  input  logic signed [W-1:0]    v [qau_pkg::VEC],
  output qau_pkg::stage_ctl_t    out_ctl,
  input  logic                   out_ready,
  output logic signed [2*W+1:0]  acc [qau_pkg::LANES],
  output logic signed [W-1:0]    a_q [qau_pkg::LANES],
  output logic signed [W-1:0]    v_q [qau_pkg::VEC]
);

  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 2;

  logic signed [AW-1:0] pe [qau_pkg::LANES][qau_pkg::LANES];
  logic signed [AW-1:0] ae [qau_pkg::LANES];
  logic signed [AW-1:0] acc_next [qau_pkg::LANES];

  assign in_ready = !out_ctl.valid || out_ready;

  always_comb begin
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      for (int j = 0; j < qau_pkg::LANES; j++) begin
        pe[i][j] = {{(AW-PW){prod[i][j][PW-1]}}, prod[i][j]};
      end
      ae[i] = {{(AW-W){a[i][W-1]}}, a[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      acc_next[i] = '0;
    end
    case (in_ctl.op)
      qau_pkg::OP_PRODUCT: begin
        acc_next[qau_pkg::IX] = pe[qau_pkg::IW][qau_pkg::IX] + pe[qau_pkg::IX][qau_pkg::IW]
                              + pe[qau_pkg::IY][qau_pkg::IZ] - pe[qau_pkg::IZ][qau_pkg::IY];
        acc_next[qau_pkg::IY] = pe[qau_pkg::IW][qau_pkg::IY] - pe[qau_pkg::IX][qau_pkg::IZ]
                              + pe[qau_pkg::IY][qau_pkg::IW] + pe[qau_pkg::IZ][qau_pkg::IX];
        acc_next[qau_pkg::IZ] = pe[qau_pkg::IW][qau_pkg::IZ] + pe[qau_pkg::IX][qau_pkg::IY]
                              - pe[qau_pkg::IY][qau_pkg::IX] + pe[qau_pkg::IZ][qau_pkg::IW];
        acc_next[qau_pkg::IW] = pe[qau_pkg::IW][qau_pkg::IW] - pe[qau_pkg::IX][qau_pkg::IX]
                              - pe[qau_pkg::IY][qau_pkg::IY] - pe[qau_pkg::IZ][qau_pkg::IZ];
      end
      qau_pkg::OP_ROTATE: begin
        // c = u x v, full precision
        acc_next[qau_pkg::IX] = pe[qau_pkg::IY][qau_pkg::IZ] - pe[qau_pkg::IZ][qau_pkg::IY];
        acc_next[qau_pkg::IY] = pe[qau_pkg::IZ][qau_pkg::IX] - pe[qau_pkg::IX][qau_pkg::IZ];
        acc_next[qau_pkg::IZ] = pe[qau_pkg::IX][qau_pkg::IY] - pe[qau_pkg::IY][qau_pkg::IX];
      end
      qau_pkg::OP_CONJ: begin
        acc_next[qau_pkg::IX] = -ae[qau_pkg::IX];
        acc_next[qau_pkg::IY] = -ae[qau_pkg::IY];
        acc_next[qau_pkg::IZ] = -ae[qau_pkg::IZ];
        acc_next[qau_pkg::IW] = ae[qau_pkg::IW];
      end
      qau_pkg::OP_DOT: begin
        acc_next[qau_pkg::IW] = pe[qau_pkg::IX][qau_pkg::IX] + pe[qau_pkg::IY][qau_pkg::IY]
                              + pe[qau_pkg::IZ][qau_pkg::IZ] + pe[qau_pkg::IW][qau_pkg::IW];
      end
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < qau_pkg::LANES; i++) begin
          acc_next[i] = pe[i][i];
        end
      end
      default: begin
        for (int i = 0; i < qau_pkg::LANES; i++) begin
          acc_next[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (in_ready) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      acc <= acc_next;
      a_q <= a;
      v_q <= v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qau_rot_stage.sv
// Third and fourth pipeline stages: second-level products of the rotation
// (w*c and u x c, split into partial products) and the exact sum before rounding.
// Depends on qau_pkg.
`default_nettype none

module qau_rot_stage #(
  parameter int W = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qau_pkg::stage_ctl_t    in_ctl,
  output logic                   in_ready,
  input  logic signed [2*W+1:0]  acc [qau_pkg::LANES],
  input  logic signed [W-1:0]    a [qau_pkg::LANES],
  input  logic signed [W-1:0]    v [qau_pkg::VEC],
  output qau_pkg::stage_ctl_t    out_ctl,
  input  logic                   out_ready,
  output logic signed [3*W+3:0]  t [qau_pkg::LANES]
);

  localparam int AW = 2 * W + 2;
  localparam int HW = 2 * W + 2;
  localparam int LW = 2 * W + 1;
  localparam int TW = 3 * W + 4;
  localparam int F  = W - 2;

  qau_pkg::stage_ctl_t ctl3;
  logic                ready3;
  logic                ready4;

  logic signed [AW-1:0] acc3 [qau_pkg::LANES];
  logic signed [W-1:0]  v3 [qau_pkg::VEC];
  logic signed [W+1:0]  c_hi [qau_pkg::VEC];
  logic signed [W:0]    c_lo [qau_pkg::VEC];
  wire  signed [TW-1:0] t_rot_v [qau_pkg::VEC];

  assign ready4   = !out_ctl.valid || out_ready;
  assign ready3   = !ctl3.valid || ready4;
  assign in_ready = ready3;

  // c = hi * 2^W + lo, lo taken unsigned
  always_comb begin
    for (int k = 0; k < qau_pkg::VEC; k++) begin
      c_hi[k] = acc[k][AW-1:W];
      c_lo[k] = {1'b0, acc[k][W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3    <= '0;
      out_ctl <= '0;
    end else begin
      if (ready3) begin
        ctl3 <= in_ctl;
      end
      if (ready4) begin
        out_ctl <= ctl3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      acc3 <= acc;
      v3   <= v;
    end
  end

  for (genvar gi = 0; gi < qau_pkg::VEC; gi++) begin : g_lane
    localparam int I1 = (gi + 1) % qau_pkg::VEC;
    localparam int I2 = (gi + 2) % qau_pkg::VEC;

    // slot 0: w * c[i], slot 1: u[i+1] * c[i+2], slot 2: u[i+2] * c[i+1]
    logic signed [HW-1:0] ph [3];
    logic signed [LW-1:0] pl [3];
    logic signed [TW-1:0] m [3];
    logic signed [TW-1:0] v_e;
    logic signed [TW-1:0] t_rot;

    always_ff @(posedge clk) begin
      if (ready3) begin
        ph[0] <= HW'(a[qau_pkg::IW]) * HW'(c_hi[gi]);
        pl[0] <= LW'(a[qau_pkg::IW]) * LW'(c_lo[gi]);
        ph[1] <= HW'(a[I1]) * HW'(c_hi[I2]);
        pl[1] <= LW'(a[I1]) * LW'(c_lo[I2]);
        ph[2] <= HW'(a[I2]) * HW'(c_hi[I1]);
        pl[2] <= LW'(a[I2]) * LW'(c_lo[I1]);
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        m[k] = ({{(TW-HW){ph[k][HW-1]}}, ph[k]} << W)
             + {{(TW-LW){pl[k][LW-1]}}, pl[k]};
      end
      v_e   = {{(TW-W){v3[gi][W-1]}}, v3[gi]};
      // v*2^2F + 2*w*c + 2*(u x c), all at 3F fraction bits
      t_rot = (v_e <<< (2 * F)) + (m[0] <<< 1) + ((m[1] - m[2]) <<< 1);
    end

    assign t_rot_v[gi] = t_rot;
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      for (int k = 0; k < qau_pkg::VEC; k++) begin
        t[k] <= (ctl3.op == qau_pkg::OP_ROTATE) ? t_rot_v[k]
              : {{(TW-AW){acc3[k][AW-1]}}, acc3[k]};
      end
      t[qau_pkg::IW] <= {{(TW-AW){acc3[qau_pkg::IW][AW-1]}}, acc3[qau_pkg::IW]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qau_round_stage.sv
// Fifth and sixth pipeline stages: round half up to the component format,
// then saturate and hold the result for the output channel. Depends on qau_pkg.
`default_nettype none
`include "assert_macros.svh"

module qau_round_stage #(
  parameter int W = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qau_pkg::stage_ctl_t    in_ctl,
  output logic                   in_ready,
  input  logic signed [3*W+3:0]  t [qau_pkg::LANES],
  output qau_pkg::stage_ctl_t    out_ctl,
  input  logic                   out_ready,
  output logic signed [W-1:0]    r [qau_pkg::LANES],
  output logic                   sat
);

  localparam int TW     = 3 * W + 4;
  localparam int F      = W - 2;
  localparam int SH_ROT = 3 * F;

  localparam logic [TW-1:0] HALF_F = {{(TW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [TW-1:0] HALF_R = {{(TW-1){1'b0}}, 1'b1} << (SH_ROT - 1);

  localparam logic signed [TW-1:0] MAX_T = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [TW-1:0] MIN_T = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MIN_W = {1'b1, {(W-1){1'b0}}};

  qau_pkg::stage_ctl_t ctl5;
  logic                ready5;
  logic                ready6;

  logic signed [TW-1:0] sum_f [qau_pkg::LANES];
  logic signed [TW-1:0] sum_r [qau_pkg::LANES];
  logic signed [TW-1:0] rnd_next [qau_pkg::LANES];
  logic signed [TW-1:0] rnd [qau_pkg::LANES];
  logic signed [W-1:0]  clip_next [qau_pkg::LANES];
  logic [qau_pkg::LANES-1:0] clipped;

  assign ready6   = !out_ctl.valid || out_ready;
  assign ready5   = !ctl5.valid || ready6;
  assign in_ready = ready5;

  always_comb begin
    for (int k = 0; k < qau_pkg::LANES; k++) begin
      sum_f[k] = t[k] + HALF_F;
      sum_r[k] = t[k] + HALF_R;
      case (in_ctl.op)
        qau_pkg::OP_PRODUCT, qau_pkg::OP_DOT, qau_pkg::OP_SCALE: begin
          rnd_next[k] = sum_f[k] >>> F;
        end
        qau_pkg::OP_ROTATE: begin
          rnd_next[k] = sum_r[k] >>> SH_ROT;
        end
        default: begin
          // conjugate is already integral; unused codes carry zero
          rnd_next[k] = t[k];
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < qau_pkg::LANES; k++) begin
      if (rnd[k] > MAX_T) begin
        clip_next[k] = MAX_W;
        clipped[k]   = 1'b1;
      end else if (rnd[k] < MIN_T) begin
        clip_next[k] = MIN_W;
        clipped[k]   = 1'b1;
      end else begin
        clip_next[k] = rnd[k][W-1:0];
        clipped[k]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5    <= '0;
      out_ctl <= '0;
    end else begin
      if (ready5) begin
        ctl5 <= in_ctl;
      end
      if (ready6) begin
        out_ctl <= ctl5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      rnd <= rnd_next;
    end
    if (ready6) begin
      r   <= clip_next;
      sat <= |clipped;
    end
  end

  `QAU_ASSERT(a_dot_xyz_zero, clk, rst, out_ctl.valid && out_ctl.op == qau_pkg::OP_DOT |-> r[qau_pkg::IX] == '0 && r[qau_pkg::IY] == '0 && r[qau_pkg::IZ] == '0, "dot result has nonzero vector part")
  `QAU_ASSERT(a_rot_w_zero, clk, rst, out_ctl.valid && out_ctl.op == qau_pkg::OP_ROTATE |-> r[qau_pkg::IW] == '0, "rotation result has nonzero w")
  `QAU_ASSERT(a_sat_at_bound, clk, rst, out_ctl.valid && sat |-> r[0] == MAX_W || r[0] == MIN_W || r[1] == MAX_W || r[1] == MIN_W || r[2] == MAX_W || r[2] == MIN_W || r[3] == MAX_W || r[3] == MIN_W, "saturation flag without a clipped component")

endmodule

`default_nettype wire

>>> rtl/core/quaternion_arithmetic_unit.sv
// Top level of the fixed-point quaternion ALU: six-stage pipeline built from
// qau_mul_stage, qau_sum_stage, qau_rot_stage and qau_round_stage. Depends on qau_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid / in_stall | operation, a_x..a_w, b_x..b_w, scale_factor
//   output   | out_valid/out_stall | r_x, r_y, r_z, r_w, saturated
//
// One item per cycle sustained while out_stall is low.
// Stage boundaries: products, sums, rotation partial products, exact sum,
// rounding, saturation/output register.
// Each stage holds its item while the next one is full; empty stages fill up
// under out_stall, so in_stall rises only when all six stages hold items.
// Synchronous reset clears every stage valid bit; no state beyond the pipeline.
`default_nettype none
`include "assert_macros.svh"

module quaternion_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        operation,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w,
  input  logic signed [COMPONENT_WIDTH-1:0] scale_factor,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] r_x,
  output logic signed [COMPONENT_WIDTH-1:0] r_y,
  output logic signed [COMPONENT_WIDTH-1:0] r_z,
  output logic signed [COMPONENT_WIDTH-1:0] r_w,
  output logic                              saturated
);

  localparam int W = COMPONENT_WIDTH;

  qau_pkg::stage_ctl_t in_ctl, ctl1, ctl2, ctl4, ctl6;
  logic ready1, ready2, ready3, ready5;

  logic signed [W-1:0]     a_in [qau_pkg::LANES];
  logic signed [W-1:0]     b_in [qau_pkg::LANES];
  logic signed [2*W-1:0]   prod1 [qau_pkg::LANES][qau_pkg::LANES];
  logic signed [W-1:0]     a1 [qau_pkg::LANES];
  logic signed [W-1:0]     v1 [qau_pkg::VEC];
  logic signed [2*W+1:0]   acc2 [qau_pkg::LANES];
  logic signed [W-1:0]     a2 [qau_pkg::LANES];
  logic signed [W-1:0]     v2 [qau_pkg::VEC];
  logic signed [3*W+3:0]   t4 [qau_pkg::LANES];
  logic signed [W-1:0]     res [qau_pkg::LANES];
  logic                    sat6;

  assign in_ctl.valid = in_valid;
  assign in_ctl.op    = qau_pkg::op_t'(operation);
  assign in_stall     = !ready1;

  assign a_in[qau_pkg::IX] = a_x;
  assign a_in[qau_pkg::IY] = a_y;
  assign a_in[qau_pkg::IZ] = a_z;
  assign a_in[qau_pkg::IW] = a_w;
  assign b_in[qau_pkg::IX] = b_x;
  assign b_in[qau_pkg::IY] = b_y;
  assign b_in[qau_pkg::IZ] = b_z;
  assign b_in[qau_pkg::IW] = b_w;

  qau_mul_stage #(.W(W)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .in_ready  (ready1),
    .a         (a_in),
    .b         (b_in),
    .s         (scale_factor),
    .out_ctl   (ctl1),
    .out_ready (ready2),
    .prod      (prod1),
    .a_q       (a1),
    .v_q       (v1)
  );

  qau_sum_stage #(.W(W)) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl1),
    .in_ready  (ready2),
    .prod      (prod1),
    .a         (a1),
    .v         (v1),
    .out_ctl   (ctl2),
    .out_ready (ready3),
    .acc       (acc2),
    .a_q       (a2),
    .v_q       (v2)
  );

  qau_rot_stage #(.W(W)) u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl2),
    .in_ready  (ready3),
    .acc       (acc2),
    .a         (a2),
    .v         (v2),
    .out_ctl   (ctl4),
    .out_ready (ready5),
    .t         (t4)
  );

  qau_round_stage #(.W(W)) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl4),
    .in_ready  (ready5),
    .t         (t4),
    .out_ctl   (ctl6),
    .out_ready (!out_stall),
    .r         (res),
    .sat       (sat6)
  );

  assign out_valid = ctl6.valid;
  assign r_x       = res[qau_pkg::IX];
  assign r_y       = res[qau_pkg::IY];
  assign r_z       = res[qau_pkg::IZ];
  assign r_w       = res[qau_pkg::IW];
  assign saturated = sat6;

  `QAU_ASSERT_ALWAYS(a_rst_empties, clk, rst |=> !out_valid, "output valid right after reset")
  `QAU_ASSERT(a_stall_only_full, clk, rst, in_stall |-> out_valid && out_stall, "input stalled while output not blocked")

endmodule

`default_nettype wire

>>> test/quaternion_result_checker.sv
// Checker for the quaternion ALU: watches both channels, predicts each result from the
// accepted item and compares field by field in arrival order.
// Depends on qau_pkg for the operation codes, lane indexes and component width.
module quaternion_result_checker #(
  parameter int W = qau_pkg::COMPONENT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [2:0]          operation,
  input  logic signed [W-1:0] a_x,
  input  logic signed [W-1:0] a_y,
  input  logic signed [W-1:0] a_z,
  input  logic signed [W-1:0] a_w,
  input  logic signed [W-1:0] b_x,
  input  logic signed [W-1:0] b_y,
  input  logic signed [W-1:0] b_z,
  input  logic signed [W-1:0] b_w,
  input  logic signed [W-1:0] scale_factor,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [W-1:0] r_x,
  input  logic signed [W-1:0] r_y,
  input  logic signed [W-1:0] r_z,
  input  logic signed [W-1:0] r_w,
  input  logic                saturated,
  output int                  mismatches,
  output int                  in_flight,
  output int                  results_checked,
  output int                  saturated_seen
);
  import qau_pkg::*;

  localparam int F = W - 2;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [W-1:0] comp_t;
  typedef struct packed {
    logic                sat;
    logic [3:0][W-1:0]   lane;
  } quat_result_t;

  localparam wide_t COMP_MAX = (wide_t'(1) <<< (W - 1)) - 1;
  localparam wide_t COMP_MIN = -(wide_t'(1) <<< (W - 1));

  quat_result_t expected_q[$];

  // round half up by sh bits, then clip; returns {clipped, value}
  function automatic logic [W:0] round_clip(wide_t v, int sh);
    wide_t r;
    r = v;
    if (sh > 0) r = (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    if (r > COMP_MAX) return {1'b1, COMP_MAX[W-1:0]};
    if (r < COMP_MIN) return {1'b1, COMP_MIN[W-1:0]};
    return {1'b0, r[W-1:0]};
  endfunction

  function automatic quat_result_t quat_alu_result(
    logic [2:0] op, comp_t ax, comp_t ay, comp_t az, comp_t aw,
    comp_t bx, comp_t by, comp_t bz, comp_t bw, comp_t sf);
    wide_t a[4];
    wide_t b[4];
    wide_t sc;
    wide_t t[4];
    wide_t c[3];
    wide_t cc;
    logic [W:0] n;
    quat_result_t res;
    int sh;
    a[IX] = ax; a[IY] = ay; a[IZ] = az; a[IW] = aw;
    b[IX] = bx; b[IY] = by; b[IZ] = bz; b[IW] = bw;
    sc = sf;
    for (int i = 0; i < LANES; i++) t[i] = 0;
    sh = F;
    case (op)
      OP_PRODUCT: begin
        t[IX] = a[IW]*b[IX] + a[IX]*b[IW] + a[IY]*b[IZ] - a[IZ]*b[IY];
        t[IY] = a[IW]*b[IY] - a[IX]*b[IZ] + a[IY]*b[IW] + a[IZ]*b[IX];
        t[IZ] = a[IW]*b[IZ] + a[IX]*b[IY] - a[IY]*b[IX] + a[IZ]*b[IW];
        t[IW] = a[IW]*b[IW] - a[IX]*b[IX] - a[IY]*b[IY] - a[IZ]*b[IZ];
      end
      OP_ROTATE: begin
        // u x v keeps 2F fraction bits, the double cross product 3F
        for (int i = 0; i < VEC; i++)
          c[i] = a[(i+1)%3]*b[(i+2)%3] - a[(i+2)%3]*b[(i+1)%3];
        for (int i = 0; i < VEC; i++) begin
          cc = a[(i+1)%3]*c[(i+2)%3] - a[(i+2)%3]*c[(i+1)%3];
          t[i] = (b[i] <<< (2*F)) + ((a[IW]*c[i]) <<< 1) + (cc <<< 1);
        end
        sh = 3*F;
      end
      OP_CONJ: begin
        t[IX] = -a[IX];
        t[IY] = -a[IY];
        t[IZ] = -a[IZ];
        t[IW] = a[IW];
        sh = 0;
      end
      OP_DOT: t[IW] = a[IX]*b[IX] + a[IY]*b[IY] + a[IZ]*b[IZ] + a[IW]*b[IW];
      OP_SCALE: for (int i = 0; i < LANES; i++) t[i] = a[i]*sc;
      default: ;  // spare codes give an all-zero result
    endcase
    res.sat = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      n = round_clip(t[i], sh);
      res.lane[i] = n[W-1:0];
      res.sat = res.sat | n[W];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    quat_result_t got;
    quat_result_t want;
    string lane_name[4];
    lane_name = '{"r_x", "r_y", "r_z", "r_w"};
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.lane[IX] = r_x;
        got.lane[IY] = r_y;
        got.lane[IZ] = r_z;
        got.lane[IW] = r_w;
        got.sat = saturated;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item outstanding: %0d %0d %0d %0d sat %0b",
                   $time, r_x, r_y, r_z, r_w, saturated);
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (want.lane[i] !== got.lane[i]) begin
              mismatches++;
              $display("%0t: %s expected %0d got %0d", $time, lane_name[i],
                       $signed(want.lane[i]), $signed(got.lane[i]));
            end
          end
          if (want.sat !== got.sat) begin
            mismatches++;
            $display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
          end
          if (want.sat) saturated_seen++;
          results_checked++;
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(quat_alu_result(operation, a_x, a_y, a_z, a_w,
                                             b_x, b_y, b_z, b_w, scale_factor));
      in_flight = expected_q.size();
    end
  end

endmodule

>>> test/tb_quaternion_arithmetic_unit.sv
// Testbench top for quaternion_arithmetic_unit: clock, reset, directed and random items,
// random input gaps, random output stalls and the verdict. Depends on qau_pkg and
// quaternion_result_checker, which does all prediction and comparison.
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int W = COMPONENT_WIDTH;
  localparam int RANDOM_ITEMS = 500;
  localparam int LIMIT = 200000;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef logic signed [W-1:0] comp_t;

  localparam comp_t ONE = comp_t'(1 << (W - 2));
  localparam comp_t MAX_C = comp_t'((1 << (W - 1)) - 1);
  localparam comp_t MIN_C = comp_t'(-(1 << (W - 1)));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [2:0] operation = OP_PRODUCT;
  comp_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
  comp_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
  comp_t scale_factor = '0;
  logic in_stall, out_valid, saturated;
  comp_t r_x, r_y, r_z, r_w;

  int mismatches, in_flight, results_checked, saturated_seen;
  int cycles = 0;
  int stall_left = 0;
  int op_count[8];
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quaternion_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .scale_factor(scale_factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .saturated(saturated)
  );

  quaternion_result_checker #(.W(W)) check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .scale_factor(scale_factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .saturated(saturated),
    .mismatches(mismatches), .in_flight(in_flight),
    .results_checked(results_checked), .saturated_seen(saturated_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, in_flight);
      $display("tb_quaternion_arithmetic_unit failed");
      $finish;
    end
  end

  // output stalls come in bursts of random length so the pipeline fills up
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < 5) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      0: return MIN_C;
      1: return MAX_C;
      2, 3, 4: return comp_t'($urandom);
      default: return comp_t'(int'($urandom_range(2 * ONE)) - ONE);  // unit range
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    op_t valid_ops[5];
    valid_ops = '{OP_PRODUCT, OP_ROTATE, OP_CONJ, OP_DOT, OP_SCALE};
    if ($urandom_range(19) == 0) return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return valid_ops[$urandom_range(4)];
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(logic [2:0] op, comp_t ax, comp_t ay, comp_t az, comp_t aw,
                           comp_t bx, comp_t by, comp_t bz, comp_t bw, comp_t sf);
    bit taken;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
    b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
    scale_factor <= sf;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
    op_count[op]++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    comp_t m;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity times B, then all-extreme products
    send_item(OP_PRODUCT, 0, 0, 0, ONE, 3000, -5000, 7000, ONE / 2, rand_comp());
    send_item(OP_PRODUCT, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 0);
    send_item(OP_PRODUCT, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 0);
    send_item(OP_PRODUCT, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C, 0);
    // 90 degrees about z, then extremes; r_w must stay zero
    send_item(OP_ROTATE, 0, 0, 11585, 11585, ONE, 0, 0, MAX_C, 0);
    send_item(OP_ROTATE, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 0);
    send_item(OP_ROTATE, MAX_C, MAX_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MAX_C, 0);
    // negating the most negative value clips
    send_item(OP_CONJ, MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C);
    send_item(OP_CONJ, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C, MAX_C);
    // dot: positive clip, small values, negative clip
    send_item(OP_DOT, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 0);
    send_item(OP_DOT, ONE / 2, -ONE / 4, 100, ONE, ONE / 2, 3, -7, -ONE / 2, MAX_C);
    send_item(OP_DOT, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C, 0);
    // scale by one half (exact ties round toward plus infinity), then extremes
    send_item(OP_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, ONE / 2);
    send_item(OP_SCALE, MIN_C, MIN_C, MIN_C, MIN_C, 0, 0, 0, 0, MIN_C);
    send_item(OP_SCALE, MAX_C, MIN_C, ONE, -ONE, MAX_C, MAX_C, MAX_C, MAX_C, 0);
    send_item(OP_SCALE, MAX_C, MAX_C, MIN_C, ONE, 0, 0, 0, 0, MAX_C);
    // spare codes
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
      m = (k % 2 == 0) ? MIN_C : MAX_C;
      send_item(k[2:0], m, m, m, m, m, m, m, m, m);
    end
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 200 && i < 300);
      if (i % 125 == 124) drain();
      send_item(rand_op(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    calm = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    $display("items: product %0d, rotate %0d, conjugate %0d, dot %0d, scale %0d, spare %0d",
             op_count[OP_PRODUCT], op_count[OP_ROTATE], op_count[OP_CONJ],
             op_count[OP_DOT], op_count[OP_SCALE], op_count[5] + op_count[6] + op_count[7]);
    $display("%0d results compared, %0d of them clipped, %0d mismatches",
             results_checked, saturated_seen, mismatches);
    if (mismatches == 0)
      $display("tb_quaternion_arithmetic_unit passed");
    else
      $display("tb_quaternion_arithmetic_unit failed");
    $finish;
  end

endmodule
